### hdl/ebbp_pkg.sv
// ebbp_pkg: register widths, register indexes, reset values and control structs
// for the erlang b blocking percent block; no dependencies
package ebbp_pkg;

    localparam int CH_W   = 5;
    localparam int PCT_W  = 7;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [1:0] REG_ALLOWED_MIN   = 2'd1;
    localparam logic [1:0] REG_ALLOWED_MAX   = 2'd2;

    localparam logic [CH_W-1:0]  CH_RESET  = 5'd1;
    localparam logic [PCT_W-1:0] MIN_RESET = 7'd0;
    localparam logic [PCT_W-1:0] MAX_RESET = 7'd100;
    localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;

    typedef struct packed {
        logic start;
    } t_step_req;

    typedef struct packed {
        logic done;
    } t_step_stat;

endpackage

### hdl/ebbp_step.sv
// ebbp_step: one recursion step b' = a*b / (k + a*b) in fixed point, bit-serial
// shift-add multiply then radix-2 restoring divide; depends on ebbp_pkg
module ebbp_step #(
    parameter int TRAFFIC_BITS  = 10,
    parameter int FRACTION_BITS = 32,
    parameter int KW            = 5
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ebbp_pkg::t_step_req      i_req,
    input  logic [TRAFFIC_BITS-1:0]  i_traffic,
    input  logic [FRACTION_BITS:0]   i_b,
    input  logic [KW-1:0]            i_k,
    output ebbp_pkg::t_step_stat     o_stat,
    output logic [FRACTION_BITS-1:0] o_q
);

    localparam int IW   = (TRAFFIC_BITS > KW) ? TRAFFIC_BITS : KW;
    localparam int DW   = FRACTION_BITS + IW + 1;
    localparam int CN   = (FRACTION_BITS > TRAFFIC_BITS) ? FRACTION_BITS : TRAFFIC_BITS;
    localparam int CNTW = $clog2(CN);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_PREP, S_DIV} t_state;

    t_state                   r_state;
    logic [CNTW-1:0]          r_cnt;
    logic [TRAFFIC_BITS-1:0]  r_mplier;
    logic [DW-1:0]            r_mcand;
    logic [DW-1:0]            r_acc;
    logic [DW-1:0]            r_den;
    logic [FRACTION_BITS-1:0] r_q;
    logic                     r_done;

    logic [DW:0]   w_rem2;
    logic [DW+1:0] w_diff;
    logic          w_ge;
    logic [DW-1:0] w_kpart;

    always_comb begin
        w_rem2  = {r_acc, 1'b0};
        w_diff  = {1'b0, w_rem2} - {2'b00, r_den};
        w_ge    = ~w_diff[DW+1];
        w_kpart = DW'(i_k) << FRACTION_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_acc    <= '0;
                        r_mcand  <= DW'(i_b);
                        r_mplier <= i_traffic;
                        r_cnt    <= '0;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt + 1'b1;
                    if (r_cnt == CNTW'(TRAFFIC_BITS - 1)) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_den   <= w_kpart + r_acc;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_acc <= w_ge ? w_diff[DW-1:0] : w_rem2[DW-1:0];
                    r_q   <= {r_q[FRACTION_BITS-2:0], w_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNTW'(FRACTION_BITS - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stat.done = r_done;
    assign o_q         = r_q;

endmodule

### hdl/erlang_b_blocking_percent.sv
// erlang_b_blocking_percent: erlang b blocking probability as a whole percent,
// apb register file, item control and percent scaling; depends on ebbp_pkg, ebbp_step
// the recursion runs n = min(channel_count, MAX_CHANNELS) steps on the shared bit-serial
// multiply/divide step, one item in flight at a time; the output register lets the next
// item in early, while the result before it waits to be taken
// reset: synchronous active low, registers return to 1, 0, 100 and the block idles
module erlang_b_blocking_percent #(
    parameter int MAX_CHANNELS  = 20,
    parameter int TRAFFIC_BITS  = 10,
    parameter int FRACTION_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [TRAFFIC_BITS-1:0]               i_offered_traffic,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [ebbp_pkg::PCT_W-1:0]            o_block_percent,
    output logic                                  o_accepted,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ebbp_pkg::APB_AW-1:0]           paddr,
    input  logic [ebbp_pkg::APB_DW-1:0]           pwdata,
    output logic [ebbp_pkg::APB_DW-1:0]           prdata,
    output logic                                  pready
);

    localparam int KW = $clog2(MAX_CHANNELS + 1);
    localparam int LW = (KW > ebbp_pkg::CH_W) ? KW : ebbp_pkg::CH_W;
    localparam int FB = FRACTION_BITS;

    typedef enum logic [1:0] {S_IDLE, S_START, S_WAIT, S_PCT} t_state;

    t_state                      r_state;
    logic [ebbp_pkg::CH_W-1:0]   r_channel_count;
    logic [ebbp_pkg::PCT_W-1:0]  r_allowed_min;
    logic [ebbp_pkg::PCT_W-1:0]  r_allowed_max;
    logic [TRAFFIC_BITS-1:0]     r_traffic;
    logic [KW-1:0]               r_k;
    logic [KW-1:0]               r_nch;
    logic [FB:0]                 r_b;
    logic                        r_out_valid;
    logic [ebbp_pkg::PCT_W-1:0]  r_block_percent;
    logic                        r_accepted;

    ebbp_pkg::t_step_req  w_req;
    ebbp_pkg::t_step_stat w_stat;
    logic [FB-1:0]        w_q;
    logic [KW-1:0]        w_lim;
    logic [FB+7:0]        w_prod;
    logic [7:0]           w_pct_raw;
    logic [ebbp_pkg::PCT_W-1:0] w_pct;
    logic                 w_acc_ok;
    logic                 w_wr;

    // register file
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= ebbp_pkg::CH_RESET;
            r_allowed_min   <= ebbp_pkg::MIN_RESET;
            r_allowed_max   <= ebbp_pkg::MAX_RESET;
        end else if (w_wr) begin
            case (paddr[3:2])
                ebbp_pkg::REG_CHANNEL_COUNT: r_channel_count <= pwdata[ebbp_pkg::CH_W-1:0];
                ebbp_pkg::REG_ALLOWED_MIN:   r_allowed_min   <= pwdata[ebbp_pkg::PCT_W-1:0];
                ebbp_pkg::REG_ALLOWED_MAX:   r_allowed_max   <= pwdata[ebbp_pkg::PCT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            ebbp_pkg::REG_CHANNEL_COUNT: prdata = ebbp_pkg::APB_DW'(r_channel_count);
            ebbp_pkg::REG_ALLOWED_MIN:   prdata = ebbp_pkg::APB_DW'(r_allowed_min);
            ebbp_pkg::REG_ALLOWED_MAX:   prdata = ebbp_pkg::APB_DW'(r_allowed_max);
            default:                     prdata = '0;
        endcase
    end

    // channel limit, percent scaling (x100 = x64 + x32 + x4) and interval check
    always_comb begin
        if (LW'(r_channel_count) > LW'(MAX_CHANNELS)) begin
            w_lim = KW'(MAX_CHANNELS);
        end else begin
            w_lim = KW'(r_channel_count);
        end
        w_prod    = ({7'd0, r_b} << 6) + ({7'd0, r_b} << 5) + ({7'd0, r_b} << 2);
        w_pct_raw = w_prod[FB+7:FB];
        w_pct     = (w_pct_raw > 8'd100) ? ebbp_pkg::PCT_FULL : w_pct_raw[6:0];
        w_acc_ok  = (w_pct >= r_allowed_min) && (w_pct <= r_allowed_max);
    end

    assign w_req.start = (r_state == S_START);

    ebbp_step #(
        .TRAFFIC_BITS  (TRAFFIC_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .KW            (KW)
    ) u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .i_traffic (r_traffic),
        .i_b       (r_b),
        .i_k       (r_k),
        .o_stat    (w_stat),
        .o_q       (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_PCT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_traffic <= i_offered_traffic;
                        r_k       <= KW'(1);
                        r_nch     <= w_lim;
                        r_b       <= (FB+1)'(1) << FB;
                        r_state   <= (w_lim == '0) ? S_PCT : S_START;
                    end
                end
                S_START: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_stat.done) begin
                        r_b <= {1'b0, w_q};
                        if (r_k == r_nch) begin
                            r_state <= S_PCT;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_START;
                        end
                    end
                end
                S_PCT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_block_percent <= w_pct;
                        r_accepted      <= w_acc_ok;
                        r_out_valid     <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_block_percent = r_block_percent;
    assign o_accepted      = r_accepted;

endmodule
